// ===== src/fps_pkg.sv =====
package fps_pkg;

	localparam int KIND_W = 3;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK      = 3'd0,
		KIND_PLAY      = 3'd1,
		KIND_PAUSE     = 3'd2,
		KIND_STOP      = 3'd3,
		KIND_STEP_FWD  = 3'd4,
		KIND_STEP_BACK = 3'd5,
		KIND_GOTO      = 3'd6,
		KIND_NONE      = 3'd7
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_COUNT = 2'd0,
		REG_PERIOD      = 2'd1,
		REG_LOOP        = 2'd2,
		REG_UNUSED      = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE      = 4'b0001,
		S_DIV_TIME  = 4'b0010,
		S_DIV_FRAME = 4'b0100,
		S_DONE      = 4'b1000
	} state_t;

endpackage

// ===== src/frame_playback_sequencer.sv =====
// commands and idle ticks go from idle to the done state, then load the result
// register when the output is free; active ticks run the time divide and,
// when looping, the frame modulo, on DW = max(TIME_BITS+1, FRAME_BITS)+1 bits
// items are taken only in idle; the single restoring subtractor produces one
// quotient bit per cycle for the time divide and the frame modulo
// reset: frame 0, paused, accumulator 0, frame_count 1, period 41667 us, no looping
module frame_playback_sequencer #(
	parameter int FRAME_BITS = 16,
	parameter int TIME_BITS  = 20
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [fps_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [((FRAME_BITS > TIME_BITS) ? FRAME_BITS : TIME_BITS)-1:0] cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [fps_pkg::KIND_W-1:0]                kind,
	input  logic [TIME_BITS-1:0]                      delta_us,
	input  logic signed [FRAME_BITS:0]                target_frame,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [FRAME_BITS-1:0]                     frame_number,
	output logic                                      running,
	output logic                                      frame_event
);
	import fps_pkg::*;

	localparam int FB = FRAME_BITS;
	localparam int TB = TIME_BITS;
	localparam int DW = ((TB + 1 > FB) ? TB + 1 : FB) + 1;
	localparam int CNT_W = $clog2(DW);

	logic [FB-1:0]    cfg_count_q;
	logic [TB-1:0]    cfg_period_q;
	logic             cfg_loop_q;

	state_t           state_q, state_d;
	logic [FB-1:0]    frame_q, frame_d;
	logic             play_q, play_d;
	logic [TB:0]      acc_q, acc_d;
	logic             ev_q, ev_d;
	logic [DW-1:0]    rem_q, rem_d;
	logic [DW-1:0]    dvd_q, dvd_d;
	logic [DW-1:0]    dvs_q, dvs_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic             out_valid_q;
	logic [FB-1:0]    out_frame_q;
	logic             out_run_q;
	logic             out_ev_q;

	logic [FB-1:0]    count;
	logic [FB-1:0]    last;
	logic [TB-1:0]    period;
	logic [FB-1:0]    frame_cl;
	logic [TB:0]      sum;
	logic [DW-1:0]    shift_val;
	logic [DW:0]      diff;
	logic             ge;
	logic [DW-1:0]    q_next;
	logic [DW-1:0]    r_next;
	logic [DW-1:0]    adv;
	logic             in_xfer;
	logic             out_free;

	assign count    = (cfg_count_q == '0) ? FB'(1) : cfg_count_q;
	assign last     = count - FB'(1);
	assign period   = (cfg_period_q == '0) ? TB'(1) : cfg_period_q;
	assign frame_cl = (frame_q > last) ? last : frame_q;
	assign sum      = acc_q + {1'b0, delta_us};

	// shared restoring divide step
	assign shift_val = {rem_q[DW-2:0], dvd_q[DW-1]};
	assign diff      = {1'b0, shift_val} - {1'b0, dvs_q};
	assign ge        = ~diff[DW];
	assign q_next    = {dvd_q[DW-2:0], ge};
	assign r_next    = ge ? diff[DW-1:0] : shift_val;
	assign adv       = DW'(frame_q) + q_next;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		frame_d = frame_q;
		play_d  = play_q;
		acc_d   = acc_q;
		ev_d    = ev_q;
		rem_d   = rem_q;
		dvd_d   = dvd_q;
		dvs_d   = dvs_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					frame_d = frame_cl;
					ev_d    = 1'b0;
					state_d = S_DONE;
					case (kind)
						KIND_TICK: begin
							if (play_q && last != '0) begin
								rem_d   = '0;
								dvd_d   = DW'(sum);
								dvs_d   = DW'(period);
								cnt_d   = CNT_W'(DW - 1);
								state_d = S_DIV_TIME;
							end
						end
						KIND_PLAY: begin
							if (last != '0) begin
								play_d = 1'b1;
							end
						end
						KIND_PAUSE: begin
							play_d = 1'b0;
						end
						KIND_STOP: begin
							play_d  = 1'b0;
							frame_d = '0;
							acc_d   = '0;
							ev_d    = 1'b1;
						end
						KIND_STEP_FWD: begin
							if (!play_q) begin
								if (frame_cl < last) begin
									frame_d = frame_cl + FB'(1);
								end else if (cfg_loop_q) begin
									frame_d = '0;
								end
								ev_d = 1'b1;
							end
						end
						KIND_STEP_BACK: begin
							if (!play_q) begin
								if (frame_cl != '0) begin
									frame_d = frame_cl - FB'(1);
								end else if (cfg_loop_q) begin
									frame_d = last;
								end
								ev_d = 1'b1;
							end
						end
						KIND_GOTO: begin
							if (target_frame[FB]) begin
								frame_d = '0;
							end else if (target_frame[FB-1:0] > last) begin
								frame_d = last;
							end else begin
								frame_d = target_frame[FB-1:0];
							end
							ev_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_DIV_TIME: begin
				rem_d = r_next;
				dvd_d = q_next;
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					state_d = S_DONE;
					acc_d   = r_next[TB:0];
					if (q_next != '0) begin
						ev_d = 1'b1;
						if (cfg_loop_q) begin
							rem_d   = '0;
							dvd_d   = adv;
							dvs_d   = DW'(count);
							cnt_d   = CNT_W'(DW - 1);
							state_d = S_DIV_FRAME;
						end else if (adv > DW'(last)) begin
							frame_d = last;
							play_d  = 1'b0;
							acc_d   = '0;
						end else begin
							frame_d = adv[FB-1:0];
						end
					end
				end
			end
			S_DIV_FRAME: begin
				rem_d = r_next;
				dvd_d = q_next;
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					frame_d = r_next[FB-1:0];
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q  <= FB'(1);
			cfg_period_q <= TB'(41667);
			cfg_loop_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_COUNT: cfg_count_q <= cfg_data[FB-1:0];
				REG_PERIOD:      cfg_period_q <= cfg_data[TB-1:0];
				REG_LOOP:        cfg_loop_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			frame_q <= '0;
			play_q  <= 1'b0;
			acc_q   <= '0;
			ev_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			frame_q <= frame_d;
			play_q  <= play_d;
			acc_q   <= acc_d;
			ev_q    <= ev_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		dvd_q <= dvd_d;
		dvs_q <= dvs_d;
	end

	// result register, loaded as the sequencer leaves the done state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_frame_q <= frame_q;
			out_run_q   <= play_q;
			out_ev_q    <= ev_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_number = out_frame_q;
	assign running      = out_run_q;
	assign frame_event  = out_ev_q;

`ifndef NO_ASSERTIONS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished item");

	a_frame_div_loops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_FRAME) |-> cfg_loop_q)
		else $error("frame modulo started without looping");

	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (frame_q <= last))
		else $error("frame index beyond last frame during an item");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_TIME || state_q == S_DIV_FRAME) |=> (state_q != S_IDLE))
		else $error("divide ended without passing through done");
`endif

endmodule
